FILE: hw/rtl/usg_pkg.sv
package usg_pkg;

  // Number of LEDs driven by the wave and the "all on" pattern
  localparam int unsigned LED_COUNT = 5;
  localparam int unsigned LED_W     = 5;   // width of the led_pattern field

  // Distance conversion: cm = (pulse_us * DIST_MUL) >> DIST_SHIFT
  localparam logic [10:0] DIST_MUL   = 11'd1126;
  localparam int unsigned DIST_SHIFT = 16;
  localparam int unsigned PROD_W     = 27;

  localparam logic [3:0] SWIPE_MAX = 4'd15;

  localparam logic [LED_W-1:0] ALL_ON   = LED_W'((9'd1 << LED_COUNT) - 9'd1);
  localparam logic [2:0]       LED_LAST = 3'(LED_COUNT - 1);

  // Item kinds carried on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ECHO = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_NEAR_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE         = 3'd1;
  localparam logic [2:0] REG_GESTURE_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_WAVE_STEP        = 3'd3;
  localparam logic [2:0] REG_TRIGGER_INTERVAL = 3'd4;

  // Reset values of the configuration registers
  localparam logic [9:0]  NEAR_THRESHOLD_RST   = 10'd20;
  localparam logic [15:0] DEBOUNCE_RST         = 16'd250;
  localparam logic [15:0] GESTURE_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] WAVE_STEP_RST        = 16'd150;
  localparam logic [15:0] TRIGGER_INTERVAL_RST = 16'd60;

  typedef struct packed {
    logic [9:0]  near_threshold_cm;
    logic [15:0] debounce_ms;
    logic [15:0] gesture_timeout_ms;
    logic [15:0] wave_step_ms;
    logic [15:0] trigger_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic             wave_active;
    logic             hand_present;
    logic [3:0]       swipe_count;
    logic [10:0]      distance_cm;
    logic             trigger_pulse;
    logic [LED_W-1:0] led_pattern;
  } result_t;

endpackage

FILE: hw/rtl/usg_core.sv
module usg_core (
  input  logic              clk,
  input  logic              rst,
  input  usg_pkg::cfg_t     cfg,
  input  logic              fire,       // apply one word this cycle
  input  logic              command,
  input  logic [15:0]       pulse_us,
  output usg_pkg::result_t  res         // result of the word being applied
);
  import usg_pkg::*;

  logic [31:0]      now_ms, now_ms_next;
  logic [31:0]      last_trigger_ms, last_trigger_ms_next;
  logic [31:0]      last_swipe_ms, last_swipe_ms_next;
  logic [31:0]      last_wave_ms, last_wave_ms_next;
  logic [3:0]       pending_swipes, pending_swipes_next;
  logic             hand_seen, hand_seen_next;
  logic             wave_running, wave_running_next;
  logic [2:0]       wave_position, wave_position_next;
  logic             wave_backward, wave_backward_next;
  logic [LED_W-1:0] led_state, led_state_next;
  logic [10:0]      last_distance, last_distance_next;
  logic             trig;

  logic [PROD_W-1:0] prod;
  logic [10:0]       echo_cm;
  logic [31:0]       tick_ms;
  logic [7:0]        wave_onehot;
  logic              back_tmp;

  // Pulse width to centimeters
  assign prod    = PROD_W'(pulse_us) * PROD_W'(DIST_MUL);
  assign echo_cm = prod[DIST_SHIFT +: 11];

  assign tick_ms     = now_ms + 32'd1;
  assign wave_onehot = 8'd1 << wave_position;

  // Next state for one word
  always_comb begin
    now_ms_next          = now_ms;
    last_trigger_ms_next = last_trigger_ms;
    last_swipe_ms_next   = last_swipe_ms;
    last_wave_ms_next    = last_wave_ms;
    pending_swipes_next  = pending_swipes;
    hand_seen_next       = hand_seen;
    wave_running_next    = wave_running;
    wave_position_next   = wave_position;
    wave_backward_next   = wave_backward;
    led_state_next       = led_state;
    last_distance_next   = last_distance;
    trig                 = 1'b0;
    back_tmp             = wave_backward;

    if (command == CMD_ECHO) begin
      last_distance_next = echo_cm;
      if (echo_cm != 11'd0) begin
        if ((echo_cm < {1'b0, cfg.near_threshold_cm}) && !hand_seen) begin
          if ((now_ms - last_swipe_ms) > {16'd0, cfg.debounce_ms}) begin
            hand_seen_next     = 1'b1;
            last_swipe_ms_next = now_ms;
            if (pending_swipes != SWIPE_MAX) begin
              pending_swipes_next = pending_swipes + 4'd1;
            end
          end
        end else if ((echo_cm >= {1'b0, cfg.near_threshold_cm}) && hand_seen) begin
          hand_seen_next = 1'b0;
        end
      end
    end else begin
      now_ms_next = tick_ms;

      // sensor trigger request
      if ((tick_ms - last_trigger_ms) >= {16'd0, cfg.trigger_interval_ms}) begin
        trig                 = 1'b1;
        last_trigger_ms_next = tick_ms;
      end

      // gesture execution after the quiet time
      if ((pending_swipes != 4'd0) &&
          ((tick_ms - last_swipe_ms) > {16'd0, cfg.gesture_timeout_ms})) begin
        if (pending_swipes == 4'd1) begin
          if (wave_running) begin
            wave_running_next = 1'b0;
            led_state_next    = ALL_ON;
          end else if (led_state != '0) begin
            led_state_next = '0;
          end else begin
            led_state_next = ALL_ON;
          end
        end else begin
          wave_running_next = 1'b1;
        end
        pending_swipes_next = 4'd0;
      end

      // wave step, bouncing between the end LEDs
      if (wave_running_next &&
          ((tick_ms - last_wave_ms) >= {16'd0, cfg.wave_step_ms})) begin
        led_state_next = wave_onehot[LED_W-1:0] & ALL_ON;
        if (wave_position >= LED_LAST) begin
          back_tmp = 1'b1;
        end
        if (wave_position == 3'd0) begin
          back_tmp = 1'b0;
        end
        wave_backward_next = back_tmp;
        wave_position_next = back_tmp ? (wave_position - 3'd1) : (wave_position + 3'd1);
        last_wave_ms_next  = tick_ms;
      end
    end
  end

  always_comb begin
    res.led_pattern   = led_state_next;
    res.trigger_pulse = trig;
    res.distance_cm   = last_distance_next;
    res.swipe_count   = pending_swipes_next;
    res.hand_present  = hand_seen_next;
    res.wave_active   = wave_running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms          <= '0;
      last_trigger_ms <= '0;
      last_swipe_ms   <= '0;
      last_wave_ms    <= '0;
      pending_swipes  <= '0;
      hand_seen       <= 1'b0;
      wave_running    <= 1'b0;
      wave_position   <= '0;
      wave_backward   <= 1'b0;
      led_state       <= '0;
      last_distance   <= '0;
    end else if (fire) begin
      now_ms          <= now_ms_next;
      last_trigger_ms <= last_trigger_ms_next;
      last_swipe_ms   <= last_swipe_ms_next;
      last_wave_ms    <= last_wave_ms_next;
      pending_swipes  <= pending_swipes_next;
      hand_seen       <= hand_seen_next;
      wave_running    <= wave_running_next;
      wave_position   <= wave_position_next;
      wave_backward   <= wave_backward_next;
      led_state       <= led_state_next;
      last_distance   <= last_distance_next;
    end
  end

  // Echo words never request a trigger
  assert property (@(posedge clk) disable iff (rst)
    (fire && (command == CMD_ECHO)) |-> !res.trigger_pulse)
    else $error("trigger requested on an echo word");

  // Presence only appears as the result of an applied echo
  assert property (@(posedge clk) disable iff (rst)
    ($rose(hand_seen) && !$past(rst)) |-> $past(fire && (command == CMD_ECHO)))
    else $error("hand presence set without an echo");

  // The time base moves only on applied ticks
  assert property (@(posedge clk) disable iff (rst)
    (!$stable(now_ms) && !$past(rst)) |-> $past(fire && (command == CMD_TICK)))
    else $error("millisecond count changed without a tick");

  // Wave position stays on the LED row
  assert property (@(posedge clk) disable iff (rst)
    wave_position <= LED_LAST)
    else $error("wave position left the LED row");

endmodule

FILE: hw/rtl/ultrasonic_swipe_gesture_led_control.sv
// Swipe-gesture LED controller for an ultrasonic range sensor.
// Input stream (s_axis): one word per event. tuser = 0 is a one-millisecond
// tick, tuser = 1 is a finished echo whose width in microseconds is in tdata.
// Output stream (m_axis): exactly one status word per input word, in order,
// carrying the LED drive bits, the trigger request of that tick, the latest
// distance, the pending swipe count, hand presence and wave state.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 threshold cm, 1 debounce ms, 2 gesture timeout ms, 3 wave step ms,
// 4 trigger interval ms); other indexes are ignored. Write only while idle.
// The accepted word is loaded into the input register; the output register
// then takes the state update when the output can advance, and the result
// is valid on m_axis from there.
// Throughput: one word per cycle when not stalled; the update is a single
// pass of logic with one 16x11 multiply and a few 32-bit time compares.
// Reset (rst, synchronous) clears all state and loads the default
// configuration. When the receiver holds tready low the output word waits;
// the input register still takes one more word, then s_axis_tready drops
// until the output moves.
module ultrasonic_swipe_gesture_led_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pulse_us
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] led_pattern, [5] trigger_pulse, [16:6] distance_cm,
  // [20:17] swipe_count, [21] hand_present, [22] wave_active, [23] zero
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import usg_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic        in_command;
  logic [15:0] in_pulse;
  logic        out_valid;
  result_t     out_word;
  result_t     res;
  logic        advance;
  logic        fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_threshold_cm   <= NEAR_THRESHOLD_RST;
      cfg.debounce_ms         <= DEBOUNCE_RST;
      cfg.gesture_timeout_ms  <= GESTURE_TIMEOUT_RST;
      cfg.wave_step_ms        <= WAVE_STEP_RST;
      cfg.trigger_interval_ms <= TRIGGER_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEAR_THRESHOLD:   cfg.near_threshold_cm   <= cfg_data[9:0];
        REG_DEBOUNCE:         cfg.debounce_ms         <= cfg_data;
        REG_GESTURE_TIMEOUT:  cfg.gesture_timeout_ms  <= cfg_data;
        REG_WAVE_STEP:        cfg.wave_step_ms        <= cfg_data;
        REG_TRIGGER_INTERVAL: cfg.trigger_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_command <= s_axis_tuser;
      in_pulse   <= s_axis_tdata;
    end
  end

  // State update
  usg_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (fire),
    .command  (in_command),
    .pulse_us (in_pulse),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_word};

endmodule
